// ----- sv/zstm_pkg.sv -----
`timescale 1ns / 1ps
// zone state table manager: shared types, codes and the per-zone transition rule
// no dependencies

package zstm_pkg;

  localparam int unsigned LBA_W         = 48;
  localparam int unsigned BPZ_W         = 25;
  localparam int unsigned CFG_DATA_W    = 48;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned ZS_W          = 3;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned OUT_W         = 5;
  localparam int unsigned NUM_ZONES_DEF = 16;

  localparam logic [BPZ_W-1:0] BPZ_RESET = BPZ_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_START      = 1'b0,
    CFG_BLOCKS_PER_ZONE = 1'b1
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN    = 3'd0,
    OP_CLOSE   = 3'd1,
    OP_FINISH  = 3'd2,
    OP_RESET   = 3'd3,
    OP_OFFLINE = 3'd4,
    OP_SET     = 3'd5
  } op_e;

  typedef enum logic [ZS_W-1:0] {
    ZS_EMPTY   = 3'd0,
    ZS_IOPEN   = 3'd1,
    ZS_EOPEN   = 3'd2,
    ZS_CLOSED  = 3'd3,
    ZS_RDONLY  = 3'd4,
    ZS_FULL    = 3'd5,
    ZS_OFFLINE = 3'd6
  } zs_e;

  typedef enum logic [1:0] {
    STAT_CHANGED  = 2'd0,
    STAT_NOCHANGE = 2'd1,
    STAT_ABORT    = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_APPLY,
    S_SWEEP,
    S_FIN
  } fsm_e;

  typedef struct packed {
    status_e         status;
    logic [ZS_W-1:0] next;
  } dec_t;

  function automatic logic op_known(input logic [OP_W-1:0] op);
    logic ok;
    case (op)
      OP_OPEN, OP_CLOSE, OP_FINISH, OP_RESET, OP_OFFLINE, OP_SET: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // effect of one command on one zone; all selects the select-all variant
  function automatic dec_t zone_decide(input logic [OP_W-1:0] op,
                                       input logic [ZS_W-1:0] cur,
                                       input logic [ZS_W-1:0] forced,
                                       input logic all);
    dec_t d;
    logic opened;
    opened   = (cur == ZS_IOPEN) || (cur == ZS_EOPEN);
    d.next   = cur;
    d.status = STAT_NOCHANGE;
    case (op)
      OP_OPEN: begin
        if (cur == ZS_CLOSED || (!all && (cur == ZS_EMPTY || cur == ZS_IOPEN))) begin
          d.next   = ZS_EOPEN;
          d.status = STAT_CHANGED;
        end else if (cur == ZS_RDONLY || cur == ZS_OFFLINE) begin
          d.status = STAT_ABORT;
        end
      end
      OP_CLOSE: begin
        if (opened) begin
          d.next   = ZS_CLOSED;
          d.status = STAT_CHANGED;
        end else if (cur != ZS_CLOSED) begin
          d.status = STAT_ABORT;
        end
      end
      OP_FINISH: begin
        if (opened || cur == ZS_CLOSED || (!all && cur == ZS_EMPTY)) begin
          d.next   = ZS_FULL;
          d.status = STAT_CHANGED;
        end else if (cur == ZS_RDONLY || cur == ZS_FULL) begin
          d.status = STAT_ABORT;
        end
      end
      OP_RESET: begin
        if (opened || cur == ZS_CLOSED || cur == ZS_FULL) begin
          d.next   = ZS_EMPTY;
          d.status = STAT_CHANGED;
        end else if (cur == ZS_RDONLY || cur == ZS_OFFLINE) begin
          d.status = STAT_ABORT;
        end
      end
      OP_OFFLINE: begin
        if (cur == ZS_RDONLY) begin
          d.next   = ZS_OFFLINE;
          d.status = STAT_CHANGED;
        end else if (cur != ZS_OFFLINE) begin
          d.status = STAT_ABORT;
        end
      end
      OP_SET: begin
        if (forced > ZS_OFFLINE) begin
          d.status = STAT_ABORT;
        end else if (forced != cur) begin
          d.next   = forced;
          d.status = STAT_CHANGED;
        end
      end
      default: d.status = STAT_ABORT;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/zstm_div.sv -----
`timescale 1ns / 1ps
// zone index divider: restoring shift-subtract, one quotient bit per cycle
// depends on zstm_pkg

module zstm_div #(
  parameter int unsigned QW = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [zstm_pkg::LBA_W-1:0]    dividend_i,
  input  logic [zstm_pkg::BPZ_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [QW-1:0]                 quot_o
);

  localparam int unsigned SW = $clog2(QW + 1);

  logic [zstm_pkg::LBA_W-1:0] rem_q, rem_d;
  logic [zstm_pkg::LBA_W-1:0] div_q, div_d;
  logic [QW-1:0]              quot_q, quot_d;
  logic [SW-1:0]              step_q, step_d;
  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic                       ge;

  // top quotient bit set means quotient >= 2^(QW-1), which is out of range anyway
  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = done_q;
    ge     = rem_q >= div_q;
    if (start_i) begin
      rem_d  = dividend_i;
      div_d  = zstm_pkg::LBA_W'(divisor_i) << (QW - 1);
      quot_d = '0;
      step_d = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      if (ge) begin
        rem_d = rem_q - div_q;
      end
      quot_d = (quot_q << 1) | QW'(ge);
      div_d  = div_q >> 1;
      step_d = step_q + SW'(1);
      if (step_q == SW'(QW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/zstm_table.sv -----
`timescale 1ns / 1ps
// zone state memory: one write and one registered read port, cleared to empty after reset
// depends on zstm_pkg

module zstm_table #(
  parameter int unsigned NUM_ZONES = zstm_pkg::NUM_ZONES_DEF,
  parameter int unsigned AW        = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [zstm_pkg::ZS_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [zstm_pkg::ZS_W-1:0] wr_data_i,
  output logic                      clr_busy_o
);

  logic [zstm_pkg::ZS_W-1:0] mem_q [NUM_ZONES];
  logic [zstm_pkg::ZS_W-1:0] rd_data_q;
  logic [AW-1:0]             clr_cnt_q, clr_cnt_d;
  logic                      clr_busy_q, clr_busy_d;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [zstm_pkg::ZS_W-1:0] wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(NUM_ZONES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    we    = clr_busy_q || wr_en_i;
    waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
    wdata = clr_busy_q ? zstm_pkg::ZS_EMPTY : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ----- sv/zone_state_table_manager.sv -----
`timescale 1ns / 1ps
// zone state table manager top: command sequencer, config registers, result register
// depends on zstm_pkg, zstm_div, zstm_table
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------------------------------------------
//  in      | in_valid_i | in_stall_o  | in_opcode_i in_select_all_i in_start_lba_i
//          |            |             | in_forced_state_i
//  out     | out_valid_o| out_stall_i | out_status_o out_previous_state_o
//          |            |             | out_zone_index_o out_zones_changed_o
//  cfg     | cfg_we_i   | -           | cfg_index_i cfg_data_i
//
// single-zone command: the zone index is formed by the shift-subtract divider one bit per cycle;
// select-all: one zone per cycle through the table's one read port and one write port.
// one command at a time; the next transfer is taken once the result is in the output register.
// after reset the table is swept to empty with the input stalled.
// a stalled result holds while the next command is taken and worked on.

module zone_state_table_manager #(
  parameter int unsigned NUM_ZONES = zstm_pkg::NUM_ZONES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [zstm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [zstm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [zstm_pkg::OP_W-1:0]            in_opcode_i,
  input  logic                                 in_select_all_i,
  input  logic [zstm_pkg::LBA_W-1:0]           in_start_lba_i,
  input  logic [zstm_pkg::ZS_W-1:0]            in_forced_state_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           out_status_o,
  output logic [zstm_pkg::ZS_W-1:0]            out_previous_state_o,
  output logic [zstm_pkg::OUT_W-1:0]           out_zone_index_o,
  output logic [zstm_pkg::OUT_W-1:0]           out_zones_changed_o
);

  localparam int unsigned AW   = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int unsigned QW   = $clog2(NUM_ZONES) + 1;
  localparam int unsigned CNTW = $clog2(NUM_ZONES + 1);
  localparam logic [zstm_pkg::OUT_W-1:0] ZoneSat = zstm_pkg::OUT_W'(NUM_ZONES);

  // config registers
  logic [zstm_pkg::LBA_W-1:0] zone_start_q;
  logic [zstm_pkg::BPZ_W-1:0] bpz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_start_q <= '0;
      bpz_q        <= zstm_pkg::BPZ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        zstm_pkg::CFG_ZONE_START:      zone_start_q <= cfg_data_i;
        zstm_pkg::CFG_BLOCKS_PER_ZONE: bpz_q        <= cfg_data_i[zstm_pkg::BPZ_W-1:0];
        default: ;
      endcase
    end
  end

  zstm_pkg::fsm_e            state_q, state_d;
  logic [zstm_pkg::OP_W-1:0] op_q, op_d;
  logic [zstm_pkg::ZS_W-1:0] forced_q, forced_d;
  zstm_pkg::status_e         res_status_q, res_status_d;
  logic [zstm_pkg::ZS_W-1:0] res_prev_q, res_prev_d;
  logic [zstm_pkg::OUT_W-1:0] res_zidx_q, res_zidx_d;
  logic [zstm_pkg::OUT_W-1:0] res_cnt_q, res_cnt_d;
  logic [CNTW-1:0]           sw_cnt_q, sw_cnt_d;
  logic                      pend_q, pend_d;
  logic [AW-1:0]             pend_addr_q, pend_addr_d;

  logic                      div_start, div_done;
  logic [QW-1:0]             div_quot;
  logic                      tbl_rd_en, tbl_wr_en, clr_busy;
  logic [AW-1:0]             tbl_rd_addr, tbl_wr_addr;
  logic [zstm_pkg::ZS_W-1:0] tbl_rd_data, tbl_wr_data;
  logic                      out_load, out_valid_q;
  logic                      in_xfer, oor;
  zstm_pkg::dec_t            dec;

  assign in_stall_o = (state_q != zstm_pkg::S_IDLE) || clr_busy;
  assign in_xfer    = in_valid_i && !in_stall_o;

  zstm_div #(
    .QW (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_start_lba_i - zone_start_q),
    .divisor_i  (bpz_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  zstm_table #(
    .NUM_ZONES (NUM_ZONES),
    .AW        (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (tbl_rd_en),
    .rd_addr_i  (tbl_rd_addr),
    .rd_data_o  (tbl_rd_data),
    .wr_en_i    (tbl_wr_en),
    .wr_addr_i  (tbl_wr_addr),
    .wr_data_i  (tbl_wr_data),
    .clr_busy_o (clr_busy)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    forced_d     = forced_q;
    res_status_d = res_status_q;
    res_prev_d   = res_prev_q;
    res_zidx_d   = res_zidx_q;
    res_cnt_d    = res_cnt_q;
    sw_cnt_d     = sw_cnt_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    div_start    = 1'b0;
    tbl_rd_en    = 1'b0;
    tbl_rd_addr  = '0;
    tbl_wr_en    = 1'b0;
    tbl_wr_addr  = pend_addr_q;
    tbl_wr_data  = '0;
    out_load     = 1'b0;
    // zero divisor gives an all-ones quotient, so it lands here too
    oor          = div_quot >= QW'(NUM_ZONES);
    dec          = zstm_pkg::zone_decide(op_q, tbl_rd_data, forced_q, state_q == zstm_pkg::S_SWEEP);

    unique case (state_q)
      zstm_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_d       = in_opcode_i;
          forced_d   = in_forced_state_i;
          res_prev_d = '0;
          res_zidx_d = '0;
          res_cnt_d  = '0;
          if (in_select_all_i) begin
            sw_cnt_d = '0;
            pend_d   = 1'b0;
            if (zstm_pkg::op_known(in_opcode_i)) begin
              res_status_d = zstm_pkg::STAT_NOCHANGE;
              state_d      = zstm_pkg::S_SWEEP;
            end else begin
              res_status_d = zstm_pkg::STAT_ABORT;
              state_d      = zstm_pkg::S_FIN;
            end
          end else begin
            div_start = 1'b1;
            state_d   = zstm_pkg::S_DIV;
          end
        end
      end
      zstm_pkg::S_DIV: begin
        if (div_done) begin
          res_zidx_d = oor ? ZoneSat : zstm_pkg::OUT_W'(div_quot);
          if (!zstm_pkg::op_known(op_q)) begin
            res_status_d = zstm_pkg::STAT_ABORT;
            state_d      = zstm_pkg::S_FIN;
          end else if (oor) begin
            res_status_d = zstm_pkg::STAT_RANGE;
            state_d      = zstm_pkg::S_FIN;
          end else begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = div_quot[AW-1:0];
            pend_addr_d = div_quot[AW-1:0];
            state_d     = zstm_pkg::S_APPLY;
          end
        end
      end
      zstm_pkg::S_APPLY: begin
        res_prev_d   = tbl_rd_data;
        res_status_d = dec.status;
        if (dec.status == zstm_pkg::STAT_CHANGED) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_data = dec.next;
          res_cnt_d   = zstm_pkg::OUT_W'(1);
        end
        state_d = zstm_pkg::S_FIN;
      end
      zstm_pkg::S_SWEEP: begin
        // read of zone i overlaps the write-back of zone i-1
        if (sw_cnt_q < CNTW'(NUM_ZONES)) begin
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = sw_cnt_q[AW-1:0];
          pend_addr_d = sw_cnt_q[AW-1:0];
          sw_cnt_d    = sw_cnt_q + CNTW'(1);
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = zstm_pkg::S_FIN;
          end
        end
        if (pend_q && dec.status == zstm_pkg::STAT_CHANGED) begin
          tbl_wr_en    = 1'b1;
          tbl_wr_data  = dec.next;
          res_cnt_d    = res_cnt_q + zstm_pkg::OUT_W'(1);
          res_status_d = zstm_pkg::STAT_CHANGED;
        end
      end
      zstm_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = zstm_pkg::S_IDLE;
        end
      end
      default: state_d = zstm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zstm_pkg::S_IDLE;
      pend_q      <= 1'b0;
      sw_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      sw_cnt_q <= sw_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    forced_q     <= forced_d;
    res_status_q <= res_status_d;
    res_prev_q   <= res_prev_d;
    res_zidx_q   <= res_zidx_d;
    res_cnt_q    <= res_cnt_d;
    pend_addr_q  <= pend_addr_d;
    if (out_load) begin
      out_status_o         <= res_status_q;
      out_previous_state_o <= res_prev_q;
      out_zone_index_o     <= res_zidx_q;
      out_zones_changed_o  <= res_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted command always leaves idle
  a_xfer_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != zstm_pkg::S_IDLE)
    else $error("accepted command did not start");

  // the sequencer never writes the table while no command is in flight
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zstm_pkg::S_IDLE) |-> !tbl_wr_en)
    else $error("table written while idle");

  // out of range reports no previous state, no changed zones and zone index NUM_ZONES
  a_range_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == zstm_pkg::STAT_RANGE) |->
      (out_previous_state_o == '0 && out_zones_changed_o == '0 &&
       out_zone_index_o == ZoneSat))
    else $error("bad out of range result");

endmodule

// ----- sim/zone_state_table_manager_tb.sv -----
`timescale 1ns / 1ps
// testbench for zone_state_table_manager: directed and random zone commands, result checking
// against an in-bench zone table predictor; depends on zstm_pkg and the block's rtl

module zone_state_table_manager_tb;

  localparam int unsigned ZONES       = zstm_pkg::NUM_ZONES_DEF;
  localparam int unsigned ZAW         = $clog2(ZONES);
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [zstm_pkg::OP_W-1:0]  OP_BAD_LO  = 3'd6;
  localparam logic [zstm_pkg::OP_W-1:0]  OP_BAD_HI  = 3'd7;
  localparam logic [zstm_pkg::ZS_W-1:0]  FORCED_BAD = 3'd7;
  localparam logic [zstm_pkg::LBA_W-1:0] LBA_MAX    = '1;

  typedef struct packed {
    zstm_pkg::status_e          status;
    logic [zstm_pkg::ZS_W-1:0]  prev;
    logic [zstm_pkg::OUT_W-1:0] zidx;
    logic [zstm_pkg::OUT_W-1:0] nchg;
  } zone_result_t;

  logic                            clk_i             = 1'b0;
  logic                            rst_ni            = 1'b0;
  logic                            cfg_we_i          = 1'b0;
  logic [zstm_pkg::CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [zstm_pkg::CFG_DATA_W-1:0] cfg_data_i        = '0;
  logic                            in_valid_i        = 1'b0;
  logic                            in_stall_o;
  logic [zstm_pkg::OP_W-1:0]       in_opcode_i       = '0;
  logic                            in_select_all_i   = 1'b0;
  logic [zstm_pkg::LBA_W-1:0]      in_start_lba_i    = '0;
  logic [zstm_pkg::ZS_W-1:0]       in_forced_state_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i       = 1'b0;
  logic [1:0]                      out_status_o;
  logic [zstm_pkg::ZS_W-1:0]       out_previous_state_o;
  logic [zstm_pkg::OUT_W-1:0]      out_zone_index_o;
  logic [zstm_pkg::OUT_W-1:0]      out_zones_changed_o;

  // predictor state: zone table and the two registers as the block should hold them
  logic [zstm_pkg::ZS_W-1:0]  zone_tbl [ZONES];
  logic [zstm_pkg::LBA_W-1:0] zone_base   = '0;
  logic [zstm_pkg::BPZ_W-1:0] zone_blocks = zstm_pkg::BPZ_RESET;

  zone_result_t zone_results_q [$];
  zone_result_t want;
  int unsigned  err_count = 0;
  int unsigned  hold_cnt  = 0;
  int unsigned  hold_reqs = 0;
  int unsigned  hold_seen = 0;
  logic         steady    = 1'b0;

  zone_state_table_manager dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_opcode_i         (in_opcode_i),
    .in_select_all_i     (in_select_all_i),
    .in_start_lba_i      (in_start_lba_i),
    .in_forced_state_i   (in_forced_state_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_previous_state_o(out_previous_state_o),
    .out_zone_index_o    (out_zone_index_o),
    .out_zones_changed_o (out_zones_changed_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // next state of one zone; a change is exactly nxt != cur
  function automatic zstm_pkg::status_e zone_transition(
      input logic [zstm_pkg::OP_W-1:0] op,
      input logic [zstm_pkg::ZS_W-1:0] cur,
      input logic [zstm_pkg::ZS_W-1:0] forced,
      input logic all,
      output logic [zstm_pkg::ZS_W-1:0] nxt);
    zstm_pkg::status_e st;
    nxt = cur;
    st  = zstm_pkg::STAT_NOCHANGE;
    case (op)
      zstm_pkg::OP_OPEN:
        case (cur)
          zstm_pkg::ZS_CLOSED:                     nxt = zstm_pkg::ZS_EOPEN;
          zstm_pkg::ZS_EMPTY, zstm_pkg::ZS_IOPEN:  if (!all) nxt = zstm_pkg::ZS_EOPEN;
          zstm_pkg::ZS_RDONLY, zstm_pkg::ZS_OFFLINE: st = zstm_pkg::STAT_ABORT;
          default: ;
        endcase
      zstm_pkg::OP_CLOSE:
        case (cur)
          zstm_pkg::ZS_IOPEN, zstm_pkg::ZS_EOPEN: nxt = zstm_pkg::ZS_CLOSED;
          zstm_pkg::ZS_CLOSED: ;
          default: st = zstm_pkg::STAT_ABORT;
        endcase
      zstm_pkg::OP_FINISH:
        case (cur)
          zstm_pkg::ZS_IOPEN, zstm_pkg::ZS_EOPEN, zstm_pkg::ZS_CLOSED: nxt = zstm_pkg::ZS_FULL;
          zstm_pkg::ZS_EMPTY:                    if (!all) nxt = zstm_pkg::ZS_FULL;
          zstm_pkg::ZS_RDONLY, zstm_pkg::ZS_FULL: st = zstm_pkg::STAT_ABORT;
          default: ;
        endcase
      zstm_pkg::OP_RESET:
        case (cur)
          zstm_pkg::ZS_IOPEN, zstm_pkg::ZS_EOPEN, zstm_pkg::ZS_CLOSED, zstm_pkg::ZS_FULL:
            nxt = zstm_pkg::ZS_EMPTY;
          zstm_pkg::ZS_RDONLY, zstm_pkg::ZS_OFFLINE: st = zstm_pkg::STAT_ABORT;
          default: ;
        endcase
      zstm_pkg::OP_OFFLINE:
        case (cur)
          zstm_pkg::ZS_RDONLY:  nxt = zstm_pkg::ZS_OFFLINE;
          zstm_pkg::ZS_OFFLINE: ;
          default:              st = zstm_pkg::STAT_ABORT;
        endcase
      zstm_pkg::OP_SET:
        if (forced == FORCED_BAD) st = zstm_pkg::STAT_ABORT;
        else nxt = forced;
      default: st = zstm_pkg::STAT_ABORT;
    endcase
    if (nxt != cur) st = zstm_pkg::STAT_CHANGED;
    return st;
  endfunction

  // applies one command to the zone table and returns the result the block owes
  function automatic zone_result_t apply_zone_cmd(input logic [zstm_pkg::OP_W-1:0] op,
                                                  input logic all,
                                                  input logic [zstm_pkg::LBA_W-1:0] lba,
                                                  input logic [zstm_pkg::ZS_W-1:0] forced);
    zone_result_t r;
    logic [zstm_pkg::LBA_W-1:0] off;
    logic [zstm_pkg::LBA_W-1:0] quo;
    logic [zstm_pkg::ZS_W-1:0]  nxt;
    logic                       inr;
    logic                       known;
    int unsigned                n;
    r     = '0;
    n     = 0;
    known = (op <= zstm_pkg::OP_SET);
    if (all) begin
      r.status = zstm_pkg::STAT_ABORT;
      if (known) begin
        for (int z = 0; z < ZONES; z++) begin
          if (zone_transition(op, zone_tbl[z[ZAW-1:0]], forced, 1'b1, nxt) ==
              zstm_pkg::STAT_CHANGED) begin
            zone_tbl[z[ZAW-1:0]] = nxt;
            n++;
          end
        end
        r.status = (n != 0) ? zstm_pkg::STAT_CHANGED : zstm_pkg::STAT_NOCHANGE;
      end
    end else begin
      off = lba - zone_base;
      quo = '0;
      inr = 1'b0;
      if (zone_blocks != 0) begin
        quo = off / zstm_pkg::LBA_W'(zone_blocks);
        inr = (quo < ZONES);
      end
      r.zidx = inr ? quo[zstm_pkg::OUT_W-1:0] : zstm_pkg::OUT_W'(ZONES);
      if (!known) begin
        r.status = zstm_pkg::STAT_ABORT;
      end else if (!inr) begin
        r.status = zstm_pkg::STAT_RANGE;
      end else begin
        r.prev   = zone_tbl[quo[ZAW-1:0]];
        r.status = zone_transition(op, r.prev, forced, 1'b0, nxt);
        if (r.status == zstm_pkg::STAT_CHANGED) begin
          zone_tbl[quo[ZAW-1:0]] = nxt;
          n = 1;
        end
      end
    end
    r.nchg = n[zstm_pkg::OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    err_count++;
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  // output side: random stall, long hold-off on request, none while steady
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_cnt  = HOLD_CYCLES;
      hold_seen = hold_reqs;
    end
    if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 27);
    end
  end

  // result transfer check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (zone_results_q.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(out_status_o), '0);
      end else begin
        want = zone_results_q.pop_front();
        if (out_status_o !== want.status)
          report_mismatch("status", 64'(out_status_o), 64'(want.status));
        if (out_previous_state_o !== want.prev)
          report_mismatch("previous_state", 64'(out_previous_state_o), 64'(want.prev));
        if (out_zone_index_o !== want.zidx)
          report_mismatch("zone_index", 64'(out_zone_index_o), 64'(want.zidx));
        if (out_zones_changed_o !== want.nchg)
          report_mismatch("zones_changed", 64'(out_zones_changed_o), 64'(want.nchg));
      end
    end
  end

  // offers one command and returns at the edge where it transfers
  task automatic send_cmd(input logic [zstm_pkg::OP_W-1:0] op, input logic all,
                          input logic [zstm_pkg::LBA_W-1:0] lba,
                          input logic [zstm_pkg::ZS_W-1:0] forced);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 27) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_opcode_i       <= op;
    in_select_all_i   <= all;
    in_start_lba_i    <= lba;
    in_forced_state_i <= forced;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    zone_results_q.push_back(apply_zone_cmd(op, all, lba, forced));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (zone_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_zone_cfg(input logic [zstm_pkg::CFG_DATA_W-1:0] base,
                                input logic [zstm_pkg::CFG_DATA_W-1:0] blocks);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= zstm_pkg::CFG_ZONE_START;
    cfg_data_i  <= base;
    @(posedge clk_i);
    zone_base   = base[zstm_pkg::LBA_W-1:0];
    cfg_index_i <= zstm_pkg::CFG_BLOCKS_PER_ZONE;
    cfg_data_i  <= blocks;
    @(posedge clk_i);
    zone_blocks = blocks[zstm_pkg::BPZ_W-1:0];
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [zstm_pkg::LBA_W-1:0] zone_lba(input int unsigned z);
    return zone_base + zstm_pkg::LBA_W'(z) * zstm_pkg::LBA_W'(zone_blocks);
  endfunction

  function automatic logic [zstm_pkg::OP_W-1:0] pick_opcode();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 15) return zstm_pkg::OP_OPEN;
    if (p < 29) return zstm_pkg::OP_CLOSE;
    if (p < 42) return zstm_pkg::OP_FINISH;
    if (p < 55) return zstm_pkg::OP_RESET;
    if (p < 64) return zstm_pkg::OP_OFFLINE;
    if (p < 96) return zstm_pkg::OP_SET;
    return (p < 98) ? OP_BAD_LO : OP_BAD_HI;
  endfunction

  // mostly lbas inside the zone area, some below it, past its end, or anywhere
  task automatic send_random_cmd();
    logic [zstm_pkg::LBA_W-1:0] lba;
    logic [63:0]                wide;
    int unsigned                p;
    wide = {$urandom, $urandom};
    p    = $urandom_range(99);
    if (zone_blocks == 0 || p >= 94)
      lba = wide[zstm_pkg::LBA_W-1:0];
    else if (p < 80)
      lba = zone_lba($urandom_range(ZONES - 1)) + zstm_pkg::LBA_W'(wide % zone_blocks);
    else if (p < 88)
      lba = zone_base - 1 - wide[9:0];
    else
      lba = zone_lba(ZONES) + wide[11:0];
    send_cmd(pick_opcode(), $urandom_range(99) < 12, lba,
             zstm_pkg::ZS_W'($urandom_range(FORCED_BAD)));
  endtask

  task automatic run_zone_phase(input logic [zstm_pkg::LBA_W-1:0] base,
                                input logic [zstm_pkg::BPZ_W-1:0] blocks,
                                input int unsigned n_cmds);
    logic [63:0] junk;
    wait_results_drained();
    // upper data bits beyond the divisor width are ignored by the register
    junk = {$urandom, $urandom};
    write_zone_cfg(base, {junk[zstm_pkg::CFG_DATA_W-1:zstm_pkg::BPZ_W], blocks});
    repeat (n_cmds) send_random_cmd();
  endtask

  function automatic logic [zstm_pkg::LBA_W-1:0] rand_lba();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[zstm_pkg::LBA_W-1:0];
  endfunction

  task automatic test_reset_defaults();
    send_cmd(zstm_pkg::OP_OPEN,    1'b0, zone_lba(0), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_CLOSE,   1'b0, zone_lba(0), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_CLOSE,   1'b0, zone_lba(1), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_FINISH,  1'b0, zone_lba(16) - 1, zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_FINISH,  1'b0, zone_lba(15), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_RESET,   1'b0, zone_lba(15), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_SET,     1'b0, zone_lba(2), zstm_pkg::ZS_RDONLY);
    send_cmd(zstm_pkg::OP_OPEN,    1'b0, zone_lba(2), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_OFFLINE, 1'b0, zone_lba(2), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_OFFLINE, 1'b0, zone_lba(2), zstm_pkg::ZS_EMPTY);
    // forced state seven aborts but still reports the zone's state
    send_cmd(zstm_pkg::OP_SET,     1'b0, zone_lba(2), FORCED_BAD);
    send_cmd(zstm_pkg::OP_OPEN,    1'b0, zone_lba(16), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_CLOSE,   1'b0, LBA_MAX, zstm_pkg::ZS_EMPTY);
    send_cmd(OP_BAD_LO,            1'b0, zone_lba(0), zstm_pkg::ZS_EMPTY);
    send_cmd(OP_BAD_HI,            1'b0, LBA_MAX, FORCED_BAD);
    send_cmd(OP_BAD_HI,            1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_SET,     1'b1, rand_lba(), zstm_pkg::ZS_IOPEN);
    send_cmd(zstm_pkg::OP_OPEN,    1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_CLOSE,   1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_OPEN,    1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_FINISH,  1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_RESET,   1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_FINISH,  1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_OFFLINE, 1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_SET,     1'b1, rand_lba(), FORCED_BAD);
  endtask

  task automatic test_config_extremes();
    wait_results_drained();
    write_zone_cfg(LBA_MAX, zstm_pkg::CFG_DATA_W'(1));
    send_cmd(zstm_pkg::OP_SET,     1'b0, LBA_MAX, zstm_pkg::ZS_RDONLY);
    // lba below the area start wraps around past the top of the lba space
    send_cmd(zstm_pkg::OP_OFFLINE, 1'b0, '0, zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_FINISH,  1'b0, zstm_pkg::LBA_W'(14), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_OPEN,    1'b0, zstm_pkg::LBA_W'(15), zstm_pkg::ZS_EMPTY);
    wait_results_drained();
    write_zone_cfg(zstm_pkg::CFG_DATA_W'('h100), zstm_pkg::CFG_DATA_W'(16));
    send_cmd(zstm_pkg::OP_CLOSE,   1'b0, zstm_pkg::LBA_W'('hff), zstm_pkg::ZS_EMPTY);
    wait_results_drained();
    write_zone_cfg(zstm_pkg::CFG_DATA_W'('h100), '0);
    send_cmd(zstm_pkg::OP_OPEN,    1'b0, zstm_pkg::LBA_W'('h100), zstm_pkg::ZS_EMPTY);
    send_cmd(zstm_pkg::OP_RESET,   1'b1, rand_lba(), zstm_pkg::ZS_EMPTY);
  endtask

  task automatic test_random_configs();
    run_zone_phase(rand_lba(), zstm_pkg::BPZ_W'($urandom_range(64, 1)), 280);
    run_zone_phase(LBA_MAX, zstm_pkg::BPZ_W'(1), 200);
    run_zone_phase(rand_lba(), zstm_pkg::BPZ_W'('h100_0000), 200);
    run_zone_phase('0, zstm_pkg::BPZ_W'(1), 150);
    run_zone_phase(rand_lba(), '1, 150);
    run_zone_phase(rand_lba(), '0, 60);
    run_zone_phase(rand_lba(), zstm_pkg::BPZ_W'($urandom_range(4096, 2)), 300);
  endtask

  // output held off while the input keeps offering, so the block backs up
  task automatic test_output_holdoff();
    wait_results_drained();
    hold_reqs++;
    repeat (16) send_random_cmd();
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (10) send_random_cmd();
      wait_results_drained();
    end
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (250) send_random_cmd();
    wait_results_drained();
    steady = 1'b0;
  endtask

  initial begin
    for (int z = 0; z < ZONES; z++) zone_tbl[z[ZAW-1:0]] = zstm_pkg::ZS_EMPTY;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_config_extremes();
    test_random_configs();
    test_output_holdoff();
    test_sender_pause();
    test_steady_stream();
    run_zone_phase('0, zstm_pkg::BPZ_RESET, 200);
    wait_results_drained();
    repeat (ZONES + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
